[hdl/pbve_pkg.sv]
`default_nettype none

package pbve_pkg;

    // Storage limits of the row stores and the row counter.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ROWM_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = 13;
    localparam int COLOR_W = 32;
    localparam int COORD_W = 14;
    localparam int KIND_W  = 2;

    localparam int IN_TDATA_W  = ((COLOR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = SIZE_W'(4096);
    localparam logic [COLOR_W-1:0] RST_BACKGROUND   = 32'hFFFF_FFFF;

    // Vertex kinds as seen on the output.
    localparam logic [KIND_W-1:0] KIND_H = 2'd0;
    localparam logic [KIND_W-1:0] KIND_V = 2'd1;
    localparam logic [KIND_W-1:0] KIND_C = 2'd2;

    // One bit per candidate vertex of a pixel, in output order.
    localparam int NUM_VTX   = 8;
    localparam int VTX_IDX_W = $clog2(NUM_VTX);
    localparam logic [VTX_IDX_W-1:0] VTX_TOP    = 3'd0;
    localparam logic [VTX_IDX_W-1:0] VTX_BOTTOM = 3'd1;
    localparam logic [VTX_IDX_W-1:0] VTX_LEFT   = 3'd2;
    localparam logic [VTX_IDX_W-1:0] VTX_RIGHT  = 3'd3;
    localparam logic [VTX_IDX_W-1:0] VTX_TL     = 3'd4;
    localparam logic [VTX_IDX_W-1:0] VTX_TR     = 3'd5;
    localparam logic [VTX_IDX_W-1:0] VTX_BL     = 3'd6;
    localparam logic [VTX_IDX_W-1:0] VTX_BR     = 3'd7;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [COLOR_W-1:0] background_color;
    } t_cfg;

    // One pixel that produces at least one vertex.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROWM_W-1:0]  row;
        logic [NUM_VTX-1:0] mask;
    } t_job;

    // Clamp a size register to 1..maxv.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (32'(v) > maxv) begin
            return SIZE_W'(maxv);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/pbve_ram.sv]
`default_nettype none

module pbve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write-first: a read of the address being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/pbve_front.sv]
`default_nettype none

module pbve_front import pbve_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_pix_valid,
    output logic               o_pix_ready,
    input  logic [COLOR_W-1:0] i_pix,
    input  logic               i_queue_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COLOR_W-1:0] r_left, n_left;

    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic [COLOR_W-1:0] bg;
    logic               accept, padding, col_last, row_nz;
    logic [31:0]        col_plus1;
    logic [COLOR_W-1:0] center, right_raw, upper;
    logic [COLOR_W-1:0] top, bottom, left, right;
    logic               dt, db, dl, dr;
    logic [NUM_VTX-1:0] mask;
    logic [COL_W-1:0]   raddr_c, raddr_r;
    logic               we_center, we_upper;

    // No word is taken while reset is held, since the counters would drop it.
    assign o_pix_ready = i_rst_n && !i_queue_full;
    assign accept      = i_pix_valid && o_pix_ready;

    always_comb begin
        w_eff     = eff_size(i_cfg.image_width, MAX_WIDTH);
        h_eff     = eff_size(i_cfg.image_height, MAX_HEIGHT);
        bg        = i_cfg.background_color;
        padding   = 32'(r_row) >= 32'(h_eff);
        row_nz    = r_row != '0;
        col_plus1 = 32'(r_col) + 32'd1;
        col_last  = col_plus1 >= 32'(w_eff);

        top    = (r_row == ROW_W'(1)) ? bg : upper;
        bottom = padding ? bg : i_pix;
        left   = (r_col == '0) ? bg : r_left;
        right  = col_last ? bg : right_raw;

        dt = center != top;
        db = center != bottom;
        dl = center != left;
        dr = center != right;

        mask             = '0;
        mask[VTX_TOP]    = dt;
        mask[VTX_BOTTOM] = db;
        mask[VTX_LEFT]   = dl;
        mask[VTX_RIGHT]  = dr;
        mask[VTX_TL]     = dt && dl && (top != left);
        mask[VTX_TR]     = dt && dr && (top != right);
        mask[VTX_BL]     = db && dl && (bottom != left);
        mask[VTX_BR]     = db && dr && (bottom != right);
        if (!row_nz || (center == bg)) begin
            mask = '0;
        end
    end

    assign o_push   = accept && (mask != '0);
    assign o_job    = '{col: r_col, row: ROWM_W'(r_row - ROW_W'(1)), mask: mask};

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (accept) begin
            if (row_nz) begin
                n_left = center;
            end
            if (col_last) begin
                n_col  = '0;
                n_left = bg;
                n_row  = padding ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= RST_BACKGROUND;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= n_left;
        end
    end

    // The stores are read one column ahead: the data seen while waiting for
    // column c is center[c], center[c+1] and upper[c] of the rows above.
    assign raddr_c   = n_col;
    assign raddr_r   = n_col + COL_W'(1);
    assign we_center = accept && !padding;
    assign we_upper  = accept && !padding && row_nz;

    pbve_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_center_here (
        .i_clk   (i_clk),
        .i_we    (we_center),
        .i_waddr (r_col),
        .i_wdata (i_pix),
        .i_raddr (raddr_c),
        .o_rdata (center)
    );

    pbve_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_center_next (
        .i_clk   (i_clk),
        .i_we    (we_center),
        .i_waddr (r_col),
        .i_wdata (i_pix),
        .i_raddr (raddr_r),
        .o_rdata (right_raw)
    );

    pbve_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (we_upper),
        .i_waddr (r_col),
        .i_wdata (center),
        .i_raddr (raddr_c),
        .o_rdata (upper)
    );

endmodule

`default_nettype wire

[hdl/pbve_queue.sv]
`default_nettype none

module pbve_queue import pbve_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue pushed while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[hdl/pbve_back.sv]
`default_nettype none

module pbve_back import pbve_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  t_job               i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_x,
    output logic [COORD_W-1:0] o_y,
    output logic [KIND_W-1:0]  o_kind,
    output logic               o_last
);

    logic                 r_busy;
    logic [COL_W-1:0]     r_col;
    logic [ROWM_W-1:0]    r_row;
    logic [NUM_VTX-1:0]   r_mask;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_x, r_y;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_last;

    logic                 out_adv, emit, load;
    logic [VTX_IDX_W-1:0] idx;
    logic [NUM_VTX-1:0]   rest;
    logic [1:0]           dx, dy;
    logic [KIND_W-1:0]    kind;

    // Lowest pending vertex of the current pixel.
    always_comb begin
        idx = '0;
        for (int i = NUM_VTX - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = VTX_IDX_W'(i);
            end
        end
        rest = r_mask & ~(NUM_VTX'(1) << idx);
    end

    always_comb begin
        unique case (idx)
            VTX_TOP:    begin dx = 2'd1; dy = 2'd0; kind = KIND_H; end
            VTX_BOTTOM: begin dx = 2'd1; dy = 2'd2; kind = KIND_H; end
            VTX_LEFT:   begin dx = 2'd0; dy = 2'd1; kind = KIND_V; end
            VTX_RIGHT:  begin dx = 2'd2; dy = 2'd1; kind = KIND_V; end
            VTX_TL:     begin dx = 2'd0; dy = 2'd0; kind = KIND_C; end
            VTX_TR:     begin dx = 2'd2; dy = 2'd0; kind = KIND_C; end
            VTX_BL:     begin dx = 2'd0; dy = 2'd2; kind = KIND_C; end
            VTX_BR:     begin dx = 2'd2; dy = 2'd2; kind = KIND_C; end
        endcase
    end

    assign out_adv = !r_out_valid || i_ready;
    assign emit    = out_adv && r_busy;
    assign load    = i_head_valid && (!r_busy || (emit && (rest == '0)));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_col  <= i_head.col;
            r_row  <= i_head.row;
            r_mask <= i_head.mask;
        end else if (emit) begin
            r_mask <= rest;
        end
        if (emit) begin
            r_x    <= COORD_W'({r_col, 1'b0}) + COORD_W'(dx);
            r_y    <= COORD_W'({r_row, 1'b0}) + COORD_W'(dy);
            r_kind <= kind;
            r_last <= rest == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && (rest == '0)) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    // Each kind sits on its own parity class of the doubled grid.
    a_h_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_H)) |-> (r_x[0] && !r_y[0]))
        else $error("horizontal edge off its grid class");

    a_v_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_V)) |-> (!r_x[0] && r_y[0]))
        else $error("vertical edge off its grid class");

    a_c_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_C)) |-> (!r_x[0] && !r_y[0]))
        else $error("corner off its grid class");

endmodule

`default_nettype wire

[hdl/pixel_boundary_vertex_extractor_top.sv]
// Pixel region boundary vertex extractor.
// Pixels enter on the slave stream, one 32-bit RGBA word per pixel, in raster
// order, followed by one padding row whose values are ignored. Vertices leave
// on the master stream: tdata carries x and y on the doubled grid, tuser the
// kind (horizontal edge, vertical edge, corner) and tlast marks the last
// vertex caused by one pixel. Pixels that cause no vertex produce no word.
// Width, height and background color are written through the configuration
// channel, which is ready whenever reset is released; write it only while idle.
// Throughput: one pixel per cycle while the four-entry job queue has room;
// the output side sends one vertex per cycle while the receiver is ready.
// The vertices of a pixel refer to the row above it and appear while the next
// row (or the padding row) streams in; once the pixel that completes it is
// accepted, its words pass the job queue, the back's mask and output registers.
// When the receiver stalls the output register holds, the queue fills, and
// then the slave tready drops until room frees up.
// Reset clears the row and column counters, the queue and the output valid,
// and loads the register reset values; both readies are low while it is held.
// The row stores are not cleared: an entry is always written before it is read.
`default_nettype none

module pixel_boundary_vertex_extractor_top import pbve_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    // Pixel stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] pixel_color
    // Vertex stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [13:0] vertex_x, [27:14] vertex_y
    output logic [KIND_W-1:0]      o_m_axis_tuser,   // [1:0] vertex_kind
    output logic                   o_m_axis_tlast    // last_of_run
);

    t_cfg               r_cfg;
    logic               push, full, pop, head_valid;
    t_job               job, head;
    logic [COORD_W-1:0] vx, vy;

    // Register writes are taken straight into the registers, so the channel only stalls in reset.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= RST_IMAGE_WIDTH;
            r_cfg.image_height     <= RST_IMAGE_HEIGHT;
            r_cfg.background_color <= RST_BACKGROUND;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:      r_cfg.image_width      <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:     r_cfg.image_height     <= i_cfg_data[SIZE_W-1:0];
                CFG_BACKGROUND_COLOR: r_cfg.background_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: counts position, reads the row stores and classifies each pixel
    // into a mask of the vertices it causes.
    pbve_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pix_valid  (i_s_axis_tvalid),
        .o_pix_ready  (o_s_axis_tready),
        .i_pix        (i_s_axis_tdata[COLOR_W-1:0]),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (job)
    );

    pbve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Back: walks the mask of each queued pixel, one vertex per word.
    pbve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_x          (vx),
        .o_y          (vy),
        .o_kind       (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({vy, vx});

endmodule

`default_nettype wire
